// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== sv/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Types, constants and the byte-wide crc-32 update for the packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

  localparam int unsigned CNT_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 3;

  localparam logic [CNT_W-1:0] HDR_BYTES      = 17'd8;
  localparam logic [CNT_W-1:0] TRAILER_BYTES  = 17'd4;
  localparam logic [CNT_W-1:0] FRAME_OVERHEAD = 17'd12;
  localparam logic [CNT_W-1:0] CNT_MAX        = 17'h1ffff;

  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE  = 2'd1;

  localparam logic [CFG_W-1:0] DATA_TYPE_RST = 3'd1;
  localparam logic [CFG_W-1:0] ACK_TYPE_RST  = 3'd2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CRC_ERR  = 2'd1,
    STATUS_LEN_ERR  = 2'd2,
    STATUS_TYPE_ERR = 2'd3
  } status_e;

  typedef struct packed {
    logic        emit;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    status_e     status;
    logic [2:0]  pkt_type;
    logic [4:0]  window_size;
    logic [7:0]  seq_number;
    logic [15:0] payload_length;
    logic [31:0] time_stamp;
  } pdc_result_t;

  // reflected crc-32, one byte per call
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/packet_deframer_crc32_core.sv =====
// ----------------------------------------------------------------------------
// packet_deframer_crc32_core
// Length-prefixed frame checker with zlib crc-32 trailer, one byte per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one datagram byte per
//   transaction, end_of_datagram_i set on the final byte. Output channel
//   (out_valid_o / out_stall_i) carries one transaction for every payload
//   byte and one for the final byte (a single transaction when both).
//   Header, trailer and excess bytes make no output transaction.
//   Results: an accepted byte is processed while it sits in the input
//   register and its result is loaded into the output register when
//   the byte leaves the input register.
//   Throughput: one byte per clock while in_stall_o is low; the crc update
//   of a whole byte is done combinationally between input and output registers.
//   Stall: while a result waits in the output register, the input register
//   still moves on if its byte makes no result; otherwise in_stall_o rises.
//   Reset clears frame state, empties both registers and loads the type
//   codes with data 1 and ack 2. The user writes type codes through cfg_we_i
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module packet_deframer_crc32_core
  import pdc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 end_of_datagram_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      payload_valid_o,
  output logic [7:0]                payload_byte_o,
  output logic                      frame_done_o,
  output logic [1:0]                status_o,
  output logic [2:0]                pkt_type_o,
  output logic [4:0]                window_size_o,
  output logic [7:0]                seq_number_o,
  output logic [15:0]               payload_length_o,
  output logic [31:0]               time_stamp_o
);

  logic [CFG_W-1:0] data_type_q, ack_type_q;
  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             s1_last_q;
  logic             out_valid_q;
  pdc_result_t      res, res_q;
  logic             out_free, s1_adv, in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_type_q <= DATA_TYPE_RST;
      ack_type_q  <= ACK_TYPE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DATA_TYPE: data_type_q <= cfg_wdata_i;
        CFG_ACK_TYPE:  ack_type_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pdc_frame_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (s1_adv),
    .byte_i      (s1_byte_q),
    .last_i      (s1_last_q),
    .data_type_i (data_type_q),
    .ack_type_i  (ack_type_q),
    .res_o       (res)
  );

  // a byte with no result never waits on the output side
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (out_free || !res.emit);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= rx_byte_i;
      s1_last_q <= end_of_datagram_i;
    end
    if (s1_adv && res.emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_valid_o  = res_q.payload_valid;
  assign payload_byte_o   = res_q.payload_byte;
  assign frame_done_o     = res_q.frame_done;
  assign status_o         = res_q.status;
  assign pkt_type_o       = res_q.pkt_type;
  assign window_size_o    = res_q.window_size;
  assign seq_number_o     = res_q.seq_number;
  assign payload_length_o = res_q.payload_length;
  assign time_stamp_o     = res_q.time_stamp;

  `ASSERT_CLK(a_result_kind,
    out_valid_o |-> (payload_valid_o || frame_done_o),
    "result transaction is neither payload nor verdict")
  `ASSERT_CLK(a_stall_cause,
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i),
    "input stalled without a blocked result")
  `ASSERT_CLK(a_no_verdict_fields,
    (out_valid_o && !frame_done_o) |-> (status_o == STATUS_OK && payload_length_o == '0),
    "verdict fields set on a payload-only result")

endmodule

`default_nettype wire

// ===== sv/pdc_frame_engine.sv =====
// ----------------------------------------------------------------------------
// pdc_frame_engine
// Per-frame state: byte count, crc, header and trailer capture, verdict.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pdc_frame_engine
  import pdc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  input  wire logic [CFG_W-1:0] data_type_i,
  input  wire logic [CFG_W-1:0] ack_type_i,
  output pdc_result_t           res_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_upd;
  logic [31:0]      crc_q, crc_d, crc_upd;
  logic [7:0]       first_q, first_d, first_upd;
  logic [7:0]       seq_q, seq_d, seq_upd;
  logic [15:0]      len_q, len_d, len_upd;
  logic [31:0]      stamp_q, stamp_d, stamp_upd;
  logic [31:0]      trl_q, trl_d, trl_upd;

  logic             is_hdr, is_pay, is_trl;
  logic [CNT_W-1:0] pay_end, trl_end, need;
  logic             crc_err, len_err, type_err;
  logic [2:0]       typ;
  status_e          status;

  always_comb begin
    cnt_upd   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 17'd1;
    crc_upd   = crc_q;
    first_upd = first_q;
    seq_upd   = seq_q;
    len_upd   = len_q;
    stamp_upd = stamp_q;
    trl_upd   = trl_q;

    pay_end = HDR_BYTES + {1'b0, len_q};
    trl_end = pay_end + TRAILER_BYTES;
    is_hdr  = cnt_q < HDR_BYTES;
    is_pay  = !is_hdr && (cnt_q < pay_end);
    is_trl  = !is_hdr && !is_pay && (cnt_q < trl_end);

    if (is_hdr) begin
      unique case (cnt_q[2:0])
        3'd0: first_upd = byte_i;
        3'd1: seq_upd = byte_i;
        3'd2: len_upd[15:8] = byte_i;
        3'd3: len_upd[7:0] = byte_i;
        3'd4: stamp_upd[7:0] = byte_i;
        3'd5: stamp_upd[15:8] = byte_i;
        3'd6: stamp_upd[23:16] = byte_i;
        3'd7: stamp_upd[31:24] = byte_i;
      endcase
    end
    if (is_hdr || is_pay) begin
      crc_upd = crc32_byte(crc_q, byte_i);
    end
    if (is_trl) begin
      trl_upd = {trl_q[23:0], byte_i};
    end

    // verdict is judged on the state including this byte
    need     = {1'b0, len_upd} + FRAME_OVERHEAD;
    typ      = first_upd[7:5];
    crc_err  = (cnt_upd >= need) && (~crc_upd != trl_upd);
    len_err  = cnt_upd != need;
    type_err = (typ != data_type_i) && (typ != ack_type_i);
    priority if (crc_err) begin
      status = STATUS_CRC_ERR;
    end else if (len_err) begin
      status = STATUS_LEN_ERR;
    end else if (type_err) begin
      status = STATUS_TYPE_ERR;
    end else begin
      status = STATUS_OK;
    end

    res_o                = '0;
    res_o.emit           = is_pay || last_i;
    res_o.payload_valid  = is_pay;
    res_o.payload_byte   = is_pay ? byte_i : 8'h00;
    if (last_i) begin
      res_o.frame_done     = 1'b1;
      res_o.status         = status;
      res_o.pkt_type       = typ;
      res_o.window_size    = first_upd[4:0];
      res_o.seq_number     = seq_upd;
      res_o.payload_length = len_upd;
      res_o.time_stamp     = stamp_upd;
    end

    if (last_i) begin
      cnt_d   = '0;
      crc_d   = CRC_INIT;
      first_d = '0;
      seq_d   = '0;
      len_d   = '0;
      stamp_d = '0;
      trl_d   = '0;
    end else begin
      cnt_d   = cnt_upd;
      crc_d   = crc_upd;
      first_d = first_upd;
      seq_d   = seq_upd;
      len_d   = len_upd;
      stamp_d = stamp_upd;
      trl_d   = trl_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      first_q <= '0;
      seq_q   <= '0;
      len_q   <= '0;
      stamp_q <= '0;
      trl_q   <= '0;
    end else if (en_i) begin
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      first_q <= first_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      stamp_q <= stamp_d;
      trl_q   <= trl_d;
    end
  end

  `ASSERT_CLK(a_frame_clears, (en_i && last_i) |=> (cnt_q == '0 && crc_q == CRC_INIT), "frame state not cleared after final byte")
  `ASSERT_NEVER(a_region_overlap, is_pay && (is_hdr || is_trl), "byte classified into two frame regions")

endmodule

`default_nettype wire
